@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// shared word types, request codes and constants of the text console writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // one screen cell: attribute in the high byte, character in the low byte
  localparam int CELL_W = 16;

  // width of the shared multiply-add result (7-bit by 5-bit product plus 7 bits)
  localparam int MAC_W = 12;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_CHAR_ATTR = 2'd0;
  localparam logic [1:0] CFG_COLS      = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;

  // configuration reset values
  localparam logic [7:0] ATTR_RESET = 8'h0A;
  localparam logic [6:0] COLS_RESET = 7'd80;
  localparam logic [4:0] ROWS_RESET = 5'd25;

  // control characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_value;
    logic [6:0] new_col;
    logic [4:0] new_row;
  } req_word_t;

  typedef struct packed {
    logic [6:0]        cursor_col;
    logic [4:0]        cursor_row;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } rsp_word_t;

  // operands of the shared multiply-add unit: y = a * b + c
  typedef struct packed {
    logic       go;
    logic [6:0] a;
    logic [4:0] b;
    logic [6:0] c;
  } mac_op_t;

endpackage

`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// character-cell text console over a store of 16-bit attribute/char cells
// ----------------------------------------------------------------------------
// A request word is taken only while the block is idle; each request gives
// exactly one response word, and a finished response waits in an output
// register so the next request can be taken meanwhile. After reset a clearing
// pass zeroes the whole store, with req_ready low. Requests are run by a small
// sequencer around one shared multiply-add unit and a one-write/one-read cell
// store. Every scroll adds a copy of the cells up one line and a zeroing of
// the bottom line, one cell per cycle through the store ports.
// Configuration words are taken at any time but are meant to be written only
// while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
  parameter int MAX_COLS  = 80,
  parameter int MAX_ROWS  = 25,
  parameter int TAB_STEPS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // request channel
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire tcw_pkg::req_word_t  req,
  // response channel
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output tcw_pkg::rsp_word_t       rsp,
  // configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  // store address and walk counter widths (counter can hold the cell count)
  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int KW = $clog2(CELL_COUNT + 1);
  localparam int SW = $clog2(TAB_STEPS + 1);

  // sequencer states, one-hot
  typedef enum logic [15:0] {
    S_INIT     = 16'h0001,  // clearing pass after reset
    S_IDLE     = 16'h0002,
    S_PUT_MUL  = 16'h0004,  // cell address of the cursor
    S_PUT      = 16'h0008,  // store the byte
    S_COL      = 16'h0010,  // column advance
    S_ROW      = 16'h0020,  // row advance
    S_NEXT     = 16'h0040,  // end of one advance step
    S_SCROLL   = 16'h0080,  // length of the region that moves up
    S_COPY     = 16'h0100,  // move cells up one line
    S_ZERO     = 16'h0200,  // zero the bottom line
    S_CLR_MUL  = 16'h0400,  // size of the used region
    S_FILL     = 16'h0800,  // fill with space and attribute
    S_RD_MUL   = 16'h1000,  // cell address of the read position
    S_RD_ISSUE = 16'h2000,
    S_RD_WAIT  = 16'h4000,
    S_DONE     = 16'h8000   // load the response register
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0] char_attr;
  logic [6:0] cols;
  logic [4:0] rows;

  // cursor and latched request
  logic [6:0]        cur_col;
  logic [4:0]        cur_row;
  logic [7:0]        rq_byte;
  logic [6:0]        rq_col;
  logic [4:0]        rq_row;
  logic [SW-1:0]     steps;      // advance steps still to run
  logic              scr;
  logic [CELL_W-1:0] data;

  // store walk
  logic [KW-1:0] k;
  logic          pend;           // copy write follows its read in the next cycle
  logic [AW-1:0] pend_addr;

  // used size after clamping
  logic [6:0] nc;
  logic [4:0] nr;

  // shared unit and store ports
  mac_op_t           mac_op;
  logic [MAC_W-1:0]  mac_y;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [KW-1:0] lim;            // end of copy or fill walk
  logic [KW-1:0] lim_all;        // end of bottom-line zeroing
  logic          k_lt_cells;
  logic          k_lt_lim;
  logic          k_lt_all;

  function automatic logic [6:0] sat_col(input logic [6:0] v, input logic [6:0] lim_c);
    return (v >= lim_c) ? lim_c - 7'd1 : v;
  endfunction

  function automatic logic [4:0] sat_row(input logic [4:0] v, input logic [4:0] lim_r);
    return (v >= lim_r) ? lim_r - 5'd1 : v;
  endfunction

  // zero acts as one, anything past the store geometry acts as its maximum
  always_comb begin
    if (cols == 7'd0) begin
      nc = 7'd1;
    end else if (32'(cols) > MAX_COLS) begin
      nc = 7'(MAX_COLS);
    end else begin
      nc = cols;
    end
    if (rows == 5'd0) begin
      nr = 5'd1;
    end else if (32'(rows) > MAX_ROWS) begin
      nr = 5'(MAX_ROWS);
    end else begin
      nr = rows;
    end
  end

  assign lim        = KW'(mac_y);
  assign lim_all    = lim + KW'(nc);
  assign k_lt_cells = (k < KW'(CELL_COUNT));
  assign k_lt_lim   = (k < lim);
  assign k_lt_all   = (k < lim_all);

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // operands of the shared multiply-add, registered result used by the following state
  always_comb begin
    mac_op.go = 1'b0;
    mac_op.a  = nc;
    mac_op.b  = nr;
    mac_op.c  = 7'd0;
    case (state)
      S_PUT_MUL: begin
        mac_op.go = 1'b1;
        mac_op.b  = cur_row;
        mac_op.c  = cur_col;
      end
      S_SCROLL: begin
        mac_op.go = 1'b1;
        mac_op.b  = nr - 5'd1;
      end
      S_CLR_MUL: begin
        mac_op.go = 1'b1;
      end
      S_RD_MUL: begin
        mac_op.go = 1'b1;
        mac_op.b  = rq_row;
        mac_op.c  = rq_col;
      end
      default: begin
        mac_op.go = 1'b0;
      end
    endcase
  end

  // store port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(k);
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = AW'(mac_y);
    case (state)
      S_INIT: begin
        ram_we = k_lt_cells;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(mac_y);
        ram_wdata = {char_attr, rq_byte};
      end
      S_COPY: begin
        // read k + cols now, write the cell read last cycle to its line above
        ram_we    = pend;
        ram_waddr = pend_addr;
        ram_wdata = ram_rdata;
        ram_re    = k_lt_lim;
        ram_raddr = AW'(k + KW'(nc));
      end
      S_ZERO: begin
        ram_we = k_lt_all;
      end
      S_FILL: begin
        ram_we    = k_lt_lim;
        ram_wdata = {char_attr, CH_SPACE};
      end
      S_RD_ISSUE: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .y   (mac_y)
  );

  tcw_screen_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, cursor and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      k         <= '0;
      pend      <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      rsp_valid <= 1'b0;
      char_attr <= ATTR_RESET;
      cols      <= COLS_RESET;
      rows      <= ROWS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHAR_ATTR: char_attr <= cfg_data;
          CFG_COLS:      cols      <= cfg_data[6:0];
          CFG_ROWS:      rows      <= cfg_data[4:0];
          default:       ;
        endcase
      end

      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_INIT: begin
          if (k_lt_cells) begin
            k <= k + KW'(1);
          end else begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            scr     <= 1'b0;
            data    <= '0;
            rq_byte <= req.byte_value;
            rq_col  <= sat_col(req.new_col, nc);
            rq_row  <= sat_row(req.new_row, nr);
            // cursor first follows a shrunken size
            cur_col <= sat_col(cur_col, nc);
            cur_row <= sat_row(cur_row, nr);
            case (req.req_type)
              REQ_WRITE: begin
                if (req.byte_value == CH_CR) begin
                  cur_col <= '0;
                  state   <= S_DONE;
                end else if (req.byte_value == CH_LF) begin
                  cur_col <= '0;
                  steps   <= SW'(1);
                  state   <= S_ROW;
                end else if (req.byte_value == CH_TAB) begin
                  steps <= SW'(TAB_STEPS);
                  state <= S_COL;
                end else begin
                  steps <= SW'(1);
                  state <= S_PUT_MUL;
                end
              end
              REQ_SET: begin
                cur_col <= sat_col(req.new_col, nc);
                cur_row <= sat_row(req.new_row, nr);
                state   <= S_DONE;
              end
              REQ_CLEAR: begin
                state <= S_CLR_MUL;
              end
              default: begin
                state <= S_RD_MUL;
              end
            endcase
          end
        end

        S_PUT_MUL: state <= S_PUT;
        S_PUT:     state <= S_COL;

        S_COL: begin
          if ({1'b0, cur_col} + 8'd1 < {1'b0, nc}) begin
            cur_col <= cur_col + 7'd1;
            state   <= S_NEXT;
          end else begin
            cur_col <= '0;
            state   <= S_ROW;
          end
        end

        S_ROW: begin
          if ({1'b0, cur_row} + 6'd1 < {1'b0, nr}) begin
            cur_row <= cur_row + 5'd1;
            state   <= S_NEXT;
          end else begin
            // past the last row: stay on it and scroll
            cur_row <= nr - 5'd1;
            scr     <= 1'b1;
            state   <= S_SCROLL;
          end
        end

        S_NEXT: begin
          if (steps == SW'(1)) begin
            state <= S_DONE;
          end else begin
            steps <= steps - SW'(1);
            state <= S_COL;
          end
        end

        S_SCROLL: begin
          k     <= '0;
          state <= S_COPY;
        end

        S_COPY: begin
          if (k_lt_lim) begin
            pend      <= 1'b1;
            pend_addr <= AW'(k);
            k         <= k + KW'(1);
          end else begin
            // last pending write goes out this cycle
            pend  <= 1'b0;
            state <= S_ZERO;
          end
        end

        S_ZERO: begin
          if (k_lt_all) begin
            k <= k + KW'(1);
          end else begin
            state <= S_NEXT;
          end
        end

        S_CLR_MUL: begin
          k     <= '0;
          state <= S_FILL;
        end

        S_FILL: begin
          if (k_lt_lim) begin
            k <= k + KW'(1);
          end else begin
            state <= S_DONE;
          end
        end

        S_RD_MUL:   state <= S_RD_ISSUE;
        S_RD_ISSUE: state <= S_RD_WAIT;

        S_RD_WAIT: begin
          data  <= ram_rdata;
          state <= S_DONE;
        end

        S_DONE: begin
          // hand over once the response register is free
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.cursor_col <= cur_col;
            rsp.cursor_row <= cur_row;
            rsp.cell_data  <= data;
            rsp.scrolled   <= scr;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tcw_mac.sv @@
// ----------------------------------------------------------------------------
// tcw_mac
// shared multiply-add unit for cell addresses and region lengths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_mac (
  input  wire logic                     clk,
  input  wire tcw_pkg::mac_op_t         op,
  output logic [tcw_pkg::MAC_W-1:0]     y
);
  import tcw_pkg::*;

  // result holds until the next issue
  always_ff @(posedge clk) begin
    if (op.go) begin
      y <= ({5'd0, op.a} * {7'd0, op.b}) + {5'd0, op.c};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tcw_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_screen_ram
// screen cell store, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [tcw_pkg::CELL_W-1:0]  rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks of the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire tcw_pkg::req_word_t req,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire tcw_pkg::rsp_word_t rsp
);
  import tcw_pkg::*;

  // reset starts the clearing pass: nothing taken, nothing shown
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!req_ready && !rsp_valid))
    else $error("request or response active right after reset");

  // one request at a time: busy right after a request word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while the previous one is in progress");

  // only a read returns cell data, and a read never scrolls
  a_scroll_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.scrolled) |-> (rsp.cell_data == '0))
    else $error("scrolled response carries cell data");

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("response word dropped or changed while stalled");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
